[hdl/cdq_pkg.sv]
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

  localparam int CNT_W = 5;            // count, capacity and front index
  localparam int REM_W = CNT_W + 1;    // unreduced buffer position
  localparam int PADDR_W = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [31:0] UNDERFLOW_VALUE = -32'sd999;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch the beat, load front index for reduction
    logic reduce;     // subtract capacity from the working position
    logic take_f;     // keep reduced front, load raw entry position
    logic emit_fail;  // refused push or pop
    logic emit_push;  // write entry, finish push
    logic emit_pop;   // finish pop with registered read data
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_ge_cap;
    logic is_push;
    logic q_empty;
    logic q_full;
  } dp_status_t;

endpackage

[hdl/circular_double_ended_queue_core.sv]
// Top level of the circular double-ended queue: register port, sequencer, datapath.
//
// Commands: drive in_cmd and in_push_value with start high while busy is low;
// the beat is taken at that edge and busy rises for the next cycle.
// in_cmd: push front, push rear, pop front, pop rear. Every beat gives one
// result, shown on the out_ ports for one cycle with out_strobe high; the
// receiver cannot stall, so it must take the result in that cycle.
// Steps from the accepting edge to out_strobe: the front index is reduced by
// repeated subtraction of the capacity (needed after a capacity change), then
// a refused push or pop gives its result; otherwise the entry position is
// reduced the same way, a push writes the entry and a pop waits for the
// registered read of the entry memory. A new beat is taken on the cycle the
// result is shown. The capacity register (byte address 0) is to be written
// over the APB port only while busy is low; the block itself does not enforce this.
// Reset empties the queue, sets the front index to zero and capacity to 16;
// entry contents are not cleared.
module circular_double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic signed [31:0]          in_push_value,
  output logic                        out_strobe,
  output logic signed [31:0]          out_pop_value,
  output logic [1:0]                  out_status,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic [cdq_pkg::CNT_W-1:0]   out_occupancy
);
  import cdq_pkg::*;

  logic [CNT_W-1:0] cap_r;
  logic             cap_sel;
  dp_ctrl_t         ctl;
  dp_status_t       sts;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == REG_CAPACITY) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = cap_sel ? {{(32-CNT_W){1'b0}}, cap_r} : '0;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .cap           (cap_r),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .out_strobe    (out_strobe),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_occupancy (out_occupancy)
  );

endmodule

[hdl/cdq_ctrl.sv]
// Sequencer for one queue operation: index reduction, access, result.
module cdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cdq_pkg::dp_status_t sts,
  output cdq_pkg::dp_ctrl_t   ctl
);
  import cdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_NORM_F = 4'b0010,
    S_NORM_A = 4'b0100,
    S_READ   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = S_NORM_F;
        end
      end
      S_NORM_F: begin
        priority if (sts.rem_ge_cap) begin
          ctl.reduce = 1'b1;
        end else if ((sts.is_push && sts.q_full) || (!sts.is_push && sts.q_empty)) begin
          ctl.emit_fail = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctl.take_f = 1'b1;
          state_nxt  = S_NORM_A;
        end
      end
      S_NORM_A: begin
        priority if (sts.rem_ge_cap) begin
          ctl.reduce = 1'b1;
        end else if (sts.is_push) begin
          ctl.emit_push = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // read data is captured at this edge
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.emit_pop = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hdl/cdq_datapath.sv]
// Entry memory, front index, count, position reduction and result registers.
module cdq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdq_pkg::dp_ctrl_t          ctl,
  output cdq_pkg::dp_status_t        sts,
  input  logic [cdq_pkg::CNT_W-1:0]  cap,
  input  logic [1:0]                 in_cmd,
  input  logic signed [31:0]         in_push_value,
  output logic                       out_strobe,
  output logic signed [31:0]         out_pop_value,
  output logic [1:0]                 out_status,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  output logic [cdq_pkg::CNT_W-1:0]  out_occupancy
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] val_r;
  cmd_t                  cmd_r;
  logic [REM_W-1:0]      rem_r, rem_nxt, raw_pos;
  logic [CNT_W-1:0]      f_r;
  logic [CNT_W-1:0]      front_r, front_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cap_eff;
  logic [AW-1:0]         addr;
  logic                  is_push;
  logic                  emit;
  logic                  strobe_r;
  logic signed [31:0]    pop_value_r;
  status_t               status_r;
  logic                  empty_r, full_r;
  logic [CNT_W-1:0]      occ_r;

  // zero acts as one, above the buffer size acts as the buffer size
  always_comb begin
    priority if (cap == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap;
    end
  end

  assign is_push = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_REAR);
  assign addr    = AW'(rem_r);
  assign emit    = ctl.emit_fail | ctl.emit_push | ctl.emit_pop;

  assign sts.rem_ge_cap = (rem_r >= {1'b0, cap_eff});
  assign sts.is_push    = is_push;
  assign sts.q_empty    = (count_r == '0);
  assign sts.q_full     = (count_r >= cap_eff);

  // unreduced entry position; rem_r holds the reduced front here
  always_comb begin
    unique case (cmd_r)
      CMD_PUSH_FRONT: raw_pos = (rem_r == '0) ? REM_W'(cap_eff - 1'b1) : rem_r - 1'b1;
      CMD_PUSH_REAR:  raw_pos = rem_r + REM_W'(count_r);
      CMD_POP_FRONT:  raw_pos = rem_r;
      CMD_POP_REAR:   raw_pos = rem_r + REM_W'(count_r) - 1'b1;
      default:        raw_pos = rem_r;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    priority if (ctl.accept) begin
      rem_nxt = REM_W'(front_r);
    end else if (ctl.reduce) begin
      rem_nxt = rem_r - {1'b0, cap_eff};
    end else if (ctl.take_f) begin
      rem_nxt = raw_pos;
    end
  end

  always_comb begin
    count_nxt = count_r;
    front_nxt = front_r;
    priority if (ctl.emit_fail) begin
      front_nxt = CNT_W'(rem_r);
    end else if (ctl.emit_push) begin
      count_nxt = count_r + 1'b1;
      front_nxt = (cmd_r == CMD_PUSH_FRONT) ? CNT_W'(rem_r) : f_r;
    end else if (ctl.emit_pop) begin
      count_nxt = count_r - 1'b1;
      if (cmd_r == CMD_POP_FRONT) begin
        front_nxt = ((REM_W'(f_r) + 1'b1) == REM_W'(cap_eff)) ? '0 : f_r + 1'b1;
      end else begin
        front_nxt = f_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      count_r  <= '0;
      front_r  <= '0;
    end else begin
      strobe_r <= emit;
      count_r  <= count_nxt;
      front_r  <= front_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (ctl.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      val_r <= DATA_WIDTH'($signed(in_push_value));
    end
    if (ctl.take_f) begin
      f_r <= CNT_W'(rem_r);
    end
    if (emit) begin
      occ_r   <= count_nxt;
      empty_r <= (count_nxt == '0);
      full_r  <= (count_nxt >= cap_eff);
      priority if (ctl.emit_fail) begin
        status_r    <= is_push ? STS_OVERFLOW : STS_UNDERFLOW;
        pop_value_r <= is_push ? '0 : UNDERFLOW_VALUE;
      end else if (ctl.emit_pop) begin
        status_r    <= STS_DONE;
        pop_value_r <= 32'($signed(rd_data_r));
      end else begin
        status_r    <= STS_DONE;
        pop_value_r <= '0;
      end
    end
  end

  // entry store: one write port, registered read
  always_ff @(posedge clk) begin
    if (ctl.emit_push) begin
      mem[addr] <= val_r;
    end
    rd_data_r <= mem[addr];
  end

  assign out_strobe    = strobe_r;
  assign out_pop_value = pop_value_r;
  assign out_status    = status_r;
  assign out_is_empty  = empty_r;
  assign out_is_full   = full_r;
  assign out_occupancy = occ_r;

endmodule
